// File: rtl/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
`default_nettype none

package mexp_pkg;

    localparam int MEXP_WIDTH = 32;
    localparam int MEXP_CNT_W = $clog2(MEXP_WIDTH);

    typedef struct packed {
        logic [MEXP_WIDTH-1:0] base_value;
        logic [MEXP_WIDTH-1:0] exponent;
        logic [MEXP_WIDTH-1:0] modulus;
    } mexp_in_t;

    typedef struct packed {
        logic [MEXP_WIDTH-1:0] power_result;
        logic                  zero_modulus;
    } mexp_out_t;

    // Which modular product the shared unit is forming.
    typedef enum logic [1:0] {
        SEL_REDUCE = 2'd0,
        SEL_MULT   = 2'd1,
        SEL_SQUARE = 2'd2
    } mexp_sel_t;

    typedef struct packed {
        logic      load;
        logic      mm_start;
        mexp_sel_t sel;
    } mexp_cmd_t;

    typedef struct packed {
        logic mm_done;
        logic zero_mod;
        logic exp_zero;
        logic exp_lsb;
        logic exp_last;
    } mexp_status_t;

endpackage

`default_nettype wire

// File: rtl/mexp_mulmod.sv
// Iterative shift-add modular multiplier, one operand bit per cycle.
`default_nettype none

module mexp_mulmod
    import mexp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [MEXP_WIDTH-1:0] a_in,
    input  wire logic [MEXP_WIDTH-1:0] b_in,
    input  wire logic [MEXP_WIDTH-1:0] m_in,
    output logic                       done,
    output logic [MEXP_WIDTH-1:0]      result
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [MEXP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MEXP_WIDTH-1:0] r_reg, r_next;
    logic [MEXP_WIDTH-1:0] a_reg, a_next;
    logic [MEXP_WIDTH-1:0] b_reg, b_next;

    logic [MEXP_WIDTH+1:0] sum;
    logic [MEXP_WIDTH+2:0] diff1, diff2;
    logic [MEXP_WIDTH-1:0] step;

    // The partial remainder is below m, so 2r + a stays below 3m and at most
    // two subtractions of m bring it back into range.
    always_comb begin
        sum   = {1'b0, r_reg, 1'b0}
              + (b_reg[MEXP_WIDTH-1] ? {2'b00, a_reg} : '0);
        diff1 = {1'b0, sum} - {3'b000, m_in};
        diff2 = {1'b0, sum} - {2'b00, m_in, 1'b0};
        if (!diff2[MEXP_WIDTH+2]) begin
            step = diff2[MEXP_WIDTH-1:0];
        end else if (!diff1[MEXP_WIDTH+2]) begin
            step = diff1[MEXP_WIDTH-1:0];
        end else begin
            step = sum[MEXP_WIDTH-1:0];
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = MEXP_CNT_W'(MEXP_WIDTH - 1);
            r_next    = '0;
            a_next    = a_in;
            b_next    = b_in;
        end else if (busy_reg) begin
            r_next = step;
            b_next = {b_reg[MEXP_WIDTH-2:0], 1'b0};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        r_reg   <= r_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done   = done_reg;
    assign result = r_reg;

`ifndef NO_ASSERTIONS
    a_result_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (r_reg < m_in))
        else $error("modular product not reduced below the modulus");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("done held for more than one cycle");

    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("multiplier started while still busy");
`endif

endmodule

`default_nettype wire

// File: rtl/mexp_datapath.sv
// Operand registers, exponent shifter and shared multiplier of the block.
`default_nettype none

module mexp_datapath
    import mexp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire mexp_in_t     in_data,
    input  wire mexp_cmd_t    cmd,
    output mexp_status_t      stat,
    output mexp_out_t         out_data
);

    logic [MEXP_WIDTH-1:0] base_reg, mod_reg, exp_reg, acc_reg, sq_reg;
    logic [MEXP_WIDTH-1:0] mm_a, mm_b, mm_result;
    logic                  mm_done;

    always_comb begin
        unique case (cmd.sel)
            SEL_REDUCE: begin
                mm_a = MEXP_WIDTH'(1);
                mm_b = base_reg;
            end
            SEL_MULT: begin
                mm_a = acc_reg;
                mm_b = sq_reg;
            end
            default: begin
                mm_a = sq_reg;
                mm_b = sq_reg;
            end
        endcase
    end

    mexp_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mm_start),
        .a_in    (mm_a),
        .b_in    (mm_b),
        .m_in    (mod_reg),
        .done    (mm_done),
        .result  (mm_result)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            base_reg <= in_data.base_value;
            exp_reg  <= in_data.exponent;
            mod_reg  <= in_data.modulus;
            acc_reg  <= MEXP_WIDTH'(1);
        end else if (mm_done) begin
            unique case (cmd.sel)
                SEL_REDUCE: sq_reg <= mm_result;
                SEL_MULT:   acc_reg <= mm_result;
                default: begin
                    sq_reg  <= mm_result;
                    exp_reg <= exp_reg >> 1;
                end
            endcase
        end
    end

    always_comb begin
        stat.mm_done  = mm_done;
        stat.zero_mod = (mod_reg == '0);
        stat.exp_zero = (exp_reg == '0);
        stat.exp_lsb  = exp_reg[0];
        stat.exp_last = (exp_reg == MEXP_WIDTH'(1));
        out_data.zero_modulus = stat.zero_mod;
        out_data.power_result = stat.zero_mod ? '0 : acc_reg;
    end

endmodule

`default_nettype wire

// File: rtl/mexp_ctrl.sv
// Sequencer that steps the square-and-multiply rounds.
`default_nettype none

module mexp_ctrl
    import mexp_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    input  wire logic          out_free,
    input  wire mexp_status_t  stat,
    output logic               in_ready,
    output logic               out_load,
    output mexp_cmd_t          cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN_REDUCE,
        ST_BIT,
        ST_RUN_MULT,
        ST_SQ_CHECK,
        ST_RUN_SQUARE,
        ST_FINISH
    } state_t;

    state_t    state_reg, state_next;
    logic      start_reg, start_next;
    mexp_sel_t sel_reg, sel_next;

    always_comb begin
        state_next = state_reg;
        start_next = 1'b0;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.zero_mod) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_RUN_REDUCE;
                    start_next = 1'b1;
                    sel_next   = SEL_REDUCE;
                end
            end
            ST_RUN_REDUCE: begin
                if (stat.mm_done) begin
                    state_next = ST_BIT;
                end
            end
            ST_BIT: begin
                if (stat.exp_zero) begin
                    state_next = ST_FINISH;
                end else if (stat.exp_lsb) begin
                    state_next = ST_RUN_MULT;
                    start_next = 1'b1;
                    sel_next   = SEL_MULT;
                end else begin
                    state_next = ST_SQ_CHECK;
                end
            end
            ST_RUN_MULT: begin
                if (stat.mm_done) begin
                    state_next = ST_SQ_CHECK;
                end
            end
            ST_SQ_CHECK: begin
                // The square after the top exponent bit is never used.
                if (stat.exp_last) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_RUN_SQUARE;
                    start_next = 1'b1;
                    sel_next   = SEL_SQUARE;
                end
            end
            ST_RUN_SQUARE: begin
                if (stat.mm_done) begin
                    state_next = ST_BIT;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
            sel_reg   <= SEL_REDUCE;
        end else begin
            state_reg <= state_next;
            start_reg <= start_next;
            sel_reg   <= sel_next;
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_load     = (state_reg == ST_FINISH) && out_free;
    assign cmd.load     = in_ready && in_valid;
    assign cmd.mm_start = start_reg;
    assign cmd.sel      = sel_reg;

endmodule

`default_nettype wire

// File: rtl/modular_exponentiation_top.sv
// Top level of the modular exponentiation block with its output register.
//
// The block computes base_value to the power exponent, modulo modulus, by
// right-to-left square-and-multiply. A transfer on the s_ channel delivers
// one item; one result transfer on the m_ channel answers it, in order.
// All arithmetic is exact: every modular product is formed by one shared
// shift-add multiplier that consumes one operand bit per cycle. The base is
// reduced first with the same unit. A zero modulus answers 0 with
// zero_modulus set; a zero exponent answers 1. The block works on one item
// at a time: s_ready is high only while it is idle. A finished result moves
// into the output register, so the next item is taken while that result
// still waits for the receiver. If the receiver stalls with the output
// register full, the finished result is held inside and no new item is
// taken until the register frees.
// Reset is synchronous and active low; it empties the output register and
// returns the sequencer to idle.
`default_nettype none

module modular_exponentiation_top
    import mexp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire mexp_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output mexp_out_t      m_data
);

    mexp_cmd_t    cmd;
    mexp_status_t stat;
    mexp_out_t    result;
    logic         out_free;
    logic         out_load;
    logic         m_valid_reg, m_valid_next;
    mexp_out_t    m_data_reg;

    // The output register can take a new result when it is empty or when
    // its current result leaves in this cycle.
    assign out_free = !m_valid_reg || m_ready;

    mexp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (s_ready),
        .out_load (out_load),
        .cmd      (cmd)
    );

    mexp_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (out_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_zero_mod_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.zero_modulus) |-> (m_data.power_result == '0))
        else $error("zero modulus result is not zero");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result loaded over a waiting result");

    a_idle_no_mult: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !cmd.mm_start)
        else $error("multiplier started while idle");
`endif

endmodule

`default_nettype wire
